// ----- rtl/gbf_pkg.sv -----
package gbf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH   = 2'd1;
  localparam logic [1:0] REG_SEARCH_DEPTH = 2'd2;

  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;

  localparam logic [6:0]  RST_GRID_HEIGHT  = 7'd64;
  localparam logic [6:0]  RST_GRID_WIDTH   = 7'd64;
  localparam logic [15:0] RST_SEARCH_DEPTH = 16'hFFFF;

  typedef struct packed {
    logic       mode;
    logic [5:0] cell_y;
    logic [5:0] cell_x;
    logic       blocked;
    logic [5:0] start_y;
    logic [5:0] start_x;
    logic [5:0] goal_y;
    logic [5:0] goal_x;
  } gbf_req_t;

  // Grid size already clamped to the range the search supports.
  typedef struct packed {
    logic [6:0]  height;
    logic [6:0]  width;
    logic [15:0] depth;
  } gbf_cfg_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  next_y;
    logic [5:0]  next_x;
    logic [12:0] path_length;
  } gbf_result_t;

  typedef struct packed {
    logic [1:0] dy;
    logic [1:0] dx;
  } gbf_off_t;

  // Neighbor offsets in scan order, rows first; 2'b11 is minus one.
  function automatic gbf_off_t gbf_nb_offset(input logic [2:0] dir);
    gbf_off_t o;
    case (dir)
      3'd0: o = '{dy: 2'b11, dx: 2'b11};
      3'd1: o = '{dy: 2'b11, dx: 2'b00};
      3'd2: o = '{dy: 2'b11, dx: 2'b01};
      3'd3: o = '{dy: 2'b00, dx: 2'b11};
      3'd4: o = '{dy: 2'b00, dx: 2'b01};
      3'd5: o = '{dy: 2'b01, dx: 2'b11};
      3'd6: o = '{dy: 2'b01, dx: 2'b00};
      3'd7: o = '{dy: 2'b01, dx: 2'b01};
      default: o = '{dy: 2'b00, dx: 2'b00};
    endcase
    return o;
  endfunction

  function automatic logic [6:0] gbf_absdiff(input logic [6:0] a, input logic [6:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/gbf_ram.sv -----
module gbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gbf_search.sv -----
module gbf_search #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  gbf_pkg::gbf_req_t    req_i,
  input  gbf_pkg::gbf_cfg_t    cfg_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output gbf_pkg::gbf_result_t res_o
);
  import gbf_pkg::*;

  localparam int unsigned RB = $clog2(MAX_ROWS);
  localparam int unsigned CB = $clog2(MAX_COLS);
  localparam int unsigned AW = RB + CB;
  localparam int unsigned NC = 1 << AW;
  // Open list entry: y, x, dist, parent, has_parent.
  localparam int unsigned OW = AW + 23;
  localparam int unsigned O_HP = 0;
  localparam int unsigned O_PAR = 1;
  localparam int unsigned O_DIST = AW + 1;
  localparam int unsigned O_X = AW + 9;
  localparam int unsigned O_Y = AW + 16;
  localparam int unsigned EW = 25;
  localparam logic [8:0] MAX_ROWS9 = 9'(MAX_ROWS);
  localparam logic [8:0] MAX_COLS9 = 9'(MAX_COLS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CLOSE_CLR, S_INIT, S_POP, S_POPW, S_LENW, S_FOUNDW,
    S_NB, S_NBW, S_INS, S_INSFIN, S_RESP
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] y, input logic [7:0] x);
    logic [8:0] yy;
    logic [8:0] xx;
    yy = {1'b0, y};
    xx = {1'b0, x};
    return {yy[RB-1:0], xx[CB-1:0]};
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [6:0]    sy_q, sy_d, sx_q, sx_d, cy_q, cy_d, cx_q, cx_d;
  logic [6:0]    h_q, h_d, w_q, w_d;
  logic [15:0]   left_q, left_d;
  logic [AW:0]   cnt_q, cnt_d, exp_q, exp_d, p_q, p_d;
  logic [AW-1:0] cur_q, cur_d, c_q, c_d;
  logic [2:0]    dir_q, dir_d;
  logic [OW-1:0] e_q, e_d;
  gbf_result_t   res_q, res_d;

  logic          obs_we, obs_wdata, obs_rdata;
  logic [AW-1:0] obs_waddr, obs_raddr;
  logic          cls_we, cls_wdata, cls_rdata;
  logic [AW-1:0] cls_waddr;
  logic          opn_we;
  logic [AW-1:0] opn_waddr, opn_raddr;
  logic [OW-1:0] opn_wdata, opn_rdata;
  logic          exp_we;
  logic [AW-1:0] exp_waddr, exp_raddr;
  logic [EW-1:0] exp_wdata, exp_rdata;

  gbf_ram #(.WIDTH(1), .DEPTH(NC)) u_obs (
    .clk_i, .we_i(obs_we), .waddr_i(obs_waddr), .wdata_i(obs_wdata),
    .raddr_i(obs_raddr), .rdata_o(obs_rdata)
  );
  gbf_ram #(.WIDTH(1), .DEPTH(NC)) u_cls (
    .clk_i, .we_i(cls_we), .waddr_i(cls_waddr), .wdata_i(cls_wdata),
    .raddr_i(obs_raddr), .rdata_o(cls_rdata)
  );
  gbf_ram #(.WIDTH(OW), .DEPTH(NC)) u_opn (
    .clk_i, .we_i(opn_we), .waddr_i(opn_waddr), .wdata_i(opn_wdata),
    .raddr_i(opn_raddr), .rdata_o(opn_rdata)
  );
  gbf_ram #(.WIDTH(EW), .DEPTH(NC)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(exp_waddr), .wdata_i(exp_wdata),
    .raddr_i(exp_raddr), .rdata_o(exp_rdata)
  );

  gbf_off_t   off;
  logic [7:0] ny, nx;
  logic       nb_ok;
  logic [7:0] nb_dist, goal_dist;
  logic       step_dir;

  always_comb begin
    off = gbf_nb_offset(dir_q);
    ny = {1'b0, cy_q} + {{6{off.dy[1]}}, off.dy};
    nx = {1'b0, cx_q} + {{6{off.dx[1]}}, off.dx};
    nb_ok = (ny < {1'b0, h_q}) && (nx < {1'b0, w_q});
    nb_dist = {1'b0, gbf_absdiff(ny[6:0], sy_q)} + {1'b0, gbf_absdiff(nx[6:0], sx_q)};
    goal_dist = {1'b0, gbf_absdiff(cy_q, sy_q)} + {1'b0, gbf_absdiff(cx_q, sx_q)};
  end

  always_comb begin
    state_d = state_q;
    clr_addr_d = clr_addr_q;
    sy_d = sy_q; sx_d = sx_q; cy_d = cy_q; cx_d = cx_q;
    h_d = h_q; w_d = w_q;
    left_d = left_q;
    cnt_d = cnt_q; exp_d = exp_q; p_d = p_q;
    cur_d = cur_q; c_d = c_q; dir_d = dir_q;
    e_d = e_q;
    res_d = res_q;
    step_dir = 1'b0;

    obs_we = 1'b0; obs_waddr = clr_addr_q; obs_wdata = 1'b0;
    obs_raddr = cell_addr(ny, nx);
    cls_we = 1'b0; cls_waddr = clr_addr_q; cls_wdata = 1'b0;
    opn_we = 1'b0; opn_waddr = p_q[AW-1:0]; opn_wdata = e_q;
    opn_raddr = cnt_q[AW-1:0] - 1'b1;
    exp_we = 1'b0; exp_waddr = cur_q; exp_wdata = '0;
    exp_raddr = opn_rdata[O_PAR +: AW];

    case (state_q)
      S_CLEAR: begin
        obs_we = 1'b1;
        cls_we = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(NC - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          if (!req_i.mode) begin
            obs_we = ({3'b0, req_i.cell_y} < MAX_ROWS9) && ({3'b0, req_i.cell_x} < MAX_COLS9);
            obs_waddr = cell_addr({2'b0, req_i.cell_y}, {2'b0, req_i.cell_x});
            obs_wdata = req_i.blocked;
          end else begin
            sy_d = {1'b0, req_i.start_y};
            sx_d = {1'b0, req_i.start_x};
            cy_d = {1'b0, req_i.goal_y};
            cx_d = {1'b0, req_i.goal_x};
            h_d = cfg_i.height;
            w_d = cfg_i.width;
            left_d = cfg_i.depth;
            res_d = '0;
            clr_addr_d = '0;
            if (({1'b0, req_i.start_y} >= cfg_i.height) ||
                ({1'b0, req_i.goal_y} >= cfg_i.height) ||
                ({1'b0, req_i.start_x} >= cfg_i.width) ||
                ({1'b0, req_i.goal_x} >= cfg_i.width)) begin
              state_d = S_RESP;
            end else begin
              state_d = S_CLOSE_CLR;
            end
          end
        end
      end
      S_CLOSE_CLR: begin
        cls_we = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(NC - 1)) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cls_we = 1'b1;
        cls_waddr = cell_addr({1'b0, cy_q}, {1'b0, cx_q});
        cls_wdata = 1'b1;
        opn_we = 1'b1;
        opn_waddr = '0;
        opn_wdata = {cy_q, cx_q, goal_dist, {AW{1'b0}}, 1'b0};
        cnt_d = (AW + 1)'(1);
        exp_d = '0;
        state_d = S_POP;
      end
      S_POP: begin
        if (cnt_q == '0) begin
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        cy_d = opn_rdata[O_Y +: 7];
        cx_d = opn_rdata[O_X +: 7];
        if (opn_rdata[O_Y +: 7] == sy_q && opn_rdata[O_X +: 7] == sx_q) begin
          state_d = opn_rdata[O_HP] ? S_FOUNDW : S_RESP;
        end else if (left_q == '0) begin
          state_d = S_RESP;
        end else begin
          left_d = left_q - 1'b1;
          cur_d = exp_q[AW-1:0];
          exp_d = exp_q + 1'b1;
          dir_d = '0;
          if (opn_rdata[O_HP]) begin
            state_d = S_LENW;
          end else begin
            exp_we = 1'b1;
            exp_waddr = exp_q[AW-1:0];
            exp_wdata = {opn_rdata[O_Y +: 6], opn_rdata[O_X +: 6], 13'd1};
            state_d = S_NB;
          end
        end
      end
      S_LENW: begin
        exp_we = 1'b1;
        exp_wdata = {cy_q[5:0], cx_q[5:0], exp_rdata[12:0] + 13'd1};
        state_d = S_NB;
      end
      S_FOUNDW: begin
        res_d.found = 1'b1;
        res_d.next_y = exp_rdata[24:19];
        res_d.next_x = exp_rdata[18:13];
        res_d.path_length = exp_rdata[12:0];
        state_d = S_RESP;
      end
      S_NB: begin
        if (nb_ok) begin
          c_d = cell_addr(ny, nx);
          e_d = {ny[6:0], nx[6:0], nb_dist, cur_q, 1'b1};
          state_d = S_NBW;
        end else begin
          step_dir = 1'b1;
        end
      end
      S_NBW: begin
        if (cls_rdata) begin
          step_dir = 1'b1;
        end else begin
          cls_we = 1'b1;
          cls_waddr = c_q;
          cls_wdata = 1'b1;
          if (obs_rdata) begin
            step_dir = 1'b1;
          end else if (cnt_q == '0) begin
            opn_we = 1'b1;
            opn_waddr = '0;
            cnt_d = cnt_q + 1'b1;
            step_dir = 1'b1;
          end else begin
            p_d = cnt_q;
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        // Shift smaller-distance entries up by one until the slot is found.
        if (opn_rdata[O_DIST +: 8] < e_q[O_DIST +: 8]) begin
          opn_we = 1'b1;
          opn_wdata = opn_rdata;
          p_d = p_q - 1'b1;
          opn_raddr = p_q[AW-1:0] - 2'd2;
          if (p_q == (AW + 1)'(1)) begin
            state_d = S_INSFIN;
          end
        end else begin
          opn_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          step_dir = 1'b1;
        end
      end
      S_INSFIN: begin
        opn_we = 1'b1;
        opn_waddr = '0;
        cnt_d = cnt_q + 1'b1;
        step_dir = 1'b1;
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (step_dir) begin
      if (dir_q == 3'd7) begin
        state_d = S_POP;
      end else begin
        dir_d = dir_q + 1'b1;
        state_d = S_NB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_addr_q <= '0;
      cnt_q <= '0;
      exp_q <= '0;
      left_q <= '0;
      dir_q <= '0;
    end else begin
      state_q <= state_d;
      clr_addr_q <= clr_addr_d;
      cnt_q <= cnt_d;
      exp_q <= exp_d;
      left_q <= left_d;
      dir_q <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sy_q <= sy_d; sx_q <= sx_d; cy_q <= cy_d; cx_q <= cx_d;
    h_q <= h_d; w_q <= w_d;
    p_q <= p_d; cur_q <= cur_d; c_q <= c_d;
    e_q <= e_d;
    res_q <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o = res_q;

endmodule

// ----- rtl/grid_best_first_pathfinder_core.sv -----
// Greedy best-first path finder over an 8-connected grid.
// Input channel (in_valid_i / in_stall_o): one transaction per item. With mode 0 the
// item writes one obstacle bit and returns no result. With mode 1 the item runs a
// query from the goal toward the start and returns exactly one result.
// Output channel (out_valid_o / out_stall_i): one transaction per query result. The
// result sits in an output register, so a new item may be accepted while it waits.
// Query flow: a start or goal outside the grid in use is answered at once. Any
// other query first sweeps all 2^(row bits + column bits) entries of the closed-mark
// memory, 4096 at the default size. Each popped node then checks its neighbor
// directions in turn, and each sorted insert shifts open-list entries up one at a
// time; the open-list memory has one read and one write port.
// One item is in work at a time.
// Reset: a clearing pass over all 2^(row bits + column bits) cells frees every
// obstacle cell; no item is accepted meanwhile, configuration writes are taken as ever.
// Stall: while out_stall_i holds a result, a finished query waits in its engine and
// the input channel stalls until the output register frees up.
module grid_best_first_pathfinder_core #(
  parameter int unsigned MAX_ROWS = gbf_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = gbf_pkg::DEF_MAX_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_mode_i,
  input  logic [5:0]  in_cell_y_i,
  input  logic [5:0]  in_cell_x_i,
  input  logic        in_blocked_i,
  input  logic [5:0]  in_start_y_i,
  input  logic [5:0]  in_start_x_i,
  input  logic [5:0]  in_goal_y_i,
  input  logic [5:0]  in_goal_x_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_found_o,
  output logic [5:0]  out_next_y_o,
  output logic [5:0]  out_next_x_o,
  output logic [12:0] out_path_length_o
);
  import gbf_pkg::*;

  localparam logic [8:0] MAX_ROWS9 = 9'(MAX_ROWS);
  localparam logic [8:0] MAX_COLS9 = 9'(MAX_COLS);

  // Configuration registers, held as written.
  logic [6:0]  height_q, width_q;
  logic [15:0] depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= RST_GRID_HEIGHT;
      width_q  <= RST_GRID_WIDTH;
      depth_q  <= RST_SEARCH_DEPTH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_HEIGHT:  height_q <= cfg_data_i[6:0];
        REG_GRID_WIDTH:   width_q  <= cfg_data_i[6:0];
        REG_SEARCH_DEPTH: depth_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A size of zero counts as one, a size above the array counts as the array size.
  logic [8:0] h9, w9;
  gbf_cfg_t   cfg;

  always_comb begin
    h9 = (height_q == '0) ? 9'd1 :
         ({2'b0, height_q} > MAX_ROWS9) ? MAX_ROWS9 : {2'b0, height_q};
    w9 = (width_q == '0) ? 9'd1 :
         ({2'b0, width_q} > MAX_COLS9) ? MAX_COLS9 : {2'b0, width_q};
    cfg.height = h9[6:0];
    cfg.width  = w9[6:0];
    cfg.depth  = depth_q;
  end

  gbf_req_t    req;
  logic        req_ready;
  logic        res_valid;
  logic        res_take;
  gbf_result_t res;

  assign req = '{mode: in_mode_i, cell_y: in_cell_y_i, cell_x: in_cell_x_i,
                 blocked: in_blocked_i, start_y: in_start_y_i, start_x: in_start_x_i,
                 goal_y: in_goal_y_i, goal_x: in_goal_x_i};

  gbf_search #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_search (
    .clk_i,
    .rst_ni,
    .req_valid_i(in_valid_i),
    .req_ready_o(req_ready),
    .req_i(req),
    .cfg_i(cfg),
    .res_valid_o(res_valid),
    .res_take_i(res_take),
    .res_o(res)
  );

  assign in_stall_o = !req_ready;

  // Output register: takes a finished result whenever it is empty or being drained.
  logic        out_valid_q;
  gbf_result_t out_q;

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = out_q.found;
  assign out_next_y_o      = out_q.next_y;
  assign out_next_x_o      = out_q.next_x;
  assign out_path_length_o = out_q.path_length;

`ifndef SYNTHESIS
  // A result without a path carries all-zero fields.
  a_nopath_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |->
      out_path_length_o == '0 && out_next_y_o == '0 && out_next_x_o == '0)
    else $error("result without a path has nonzero fields");

  // A finished result waits in the engine unchanged until the output register takes it.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result lost or changed");

  // No new item is taken while a result is still pending in the engine.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("item accepted while result pending");
`endif

endmodule
